/* rtl/core/txr_pkg.sv */
// shared types, register map, character codes and the 8x8 font table of the text rasterizer
`default_nettype none

package txr_pkg;

   // build-time defaults
   localparam int MAX_SCALE_DEFAULT = 8;
   localparam int MAX_DIM_DEFAULT   = 4096;

   // one result row is at most eight font columns times the largest scale
   localparam int MASK_BITS = 64;

   // register map, index is paddr[4:2]
   localparam int ADDR_BITS = 5;
   localparam logic [2:0] REG_ORIGIN_X       = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y       = 3'd1;
   localparam logic [2:0] REG_GLYPH_SCALE    = 3'd2;
   localparam logic [2:0] REG_SURFACE_WIDTH  = 3'd3;
   localparam logic [2:0] REG_SURFACE_HEIGHT = 3'd4;
   localparam logic [2:0] REG_DRAW_COLOR     = 3'd5;

   // register reset values
   localparam logic signed [15:0] ORIGIN_X_RESET       = 16'sd0;
   localparam logic signed [15:0] ORIGIN_Y_RESET       = 16'sd0;
   localparam logic [3:0]         GLYPH_SCALE_RESET    = 4'd1;
   localparam logic [12:0]        SURFACE_WIDTH_RESET  = 13'd640;
   localparam logic [12:0]        SURFACE_HEIGHT_RESET = 13'd480;
   localparam logic [31:0]        DRAW_COLOR_RESET     = 32'hFFFF_FFFF;

   // character codes with a meaning of their own
   localparam logic [7:0] CODE_NUL     = 8'd0;
   localparam logic [7:0] CODE_NEWLINE = 8'd10;

   // configuration as seen by the datapath
   typedef struct packed {
      logic signed [15:0] origin_x;
      logic signed [15:0] origin_y;
      logic [3:0]         glyph_scale;
      logic [12:0]        surface_width;
      logic [12:0]        surface_height;
      logic [31:0]        draw_color;
   } cfg_type;

   // input transfer payload
   typedef struct packed {
      logic [7:0] char_code;
      logic       first_of_text;
   } req_type;

   // result transfer payload
   typedef struct packed {
      logic signed [15:0]     row_y;
      logic signed [15:0]     span_x;
      logic [MASK_BITS-1:0]   pixel_mask;
      logic [31:0]            pixel_color;
      logic                   last_row;
   } rsp_type;

   // eight row bytes, row 0 at the top, bit 0 the leftmost column
   typedef logic [7:0] glyph_type [8];

   localparam glyph_type FONT_DIGITS [10] = '{
      '{8'h0E,8'h11,8'h19,8'h15,8'h13,8'h11,8'h0E,8'h00},
      '{8'h04,8'h06,8'h04,8'h04,8'h04,8'h04,8'h0E,8'h00},
      '{8'h0E,8'h11,8'h10,8'h08,8'h04,8'h02,8'h1F,8'h00},
      '{8'h0E,8'h11,8'h10,8'h0C,8'h10,8'h11,8'h0E,8'h00},
      '{8'h08,8'h0C,8'h0A,8'h09,8'h1F,8'h08,8'h08,8'h00},
      '{8'h1F,8'h01,8'h0F,8'h10,8'h10,8'h11,8'h0E,8'h00},
      '{8'h0C,8'h02,8'h01,8'h0F,8'h11,8'h11,8'h0E,8'h00},
      '{8'h1F,8'h10,8'h08,8'h04,8'h02,8'h02,8'h02,8'h00},
      '{8'h0E,8'h11,8'h11,8'h0E,8'h11,8'h11,8'h0E,8'h00},
      '{8'h0E,8'h11,8'h11,8'h1E,8'h10,8'h08,8'h06,8'h00}
   };

   localparam glyph_type FONT_LETTERS [26] = '{
      '{8'h0E,8'h11,8'h11,8'h1F,8'h11,8'h11,8'h11,8'h00},
      '{8'h0F,8'h11,8'h11,8'h0F,8'h11,8'h11,8'h0F,8'h00},
      '{8'h0E,8'h11,8'h01,8'h01,8'h01,8'h11,8'h0E,8'h00},
      '{8'h0F,8'h11,8'h11,8'h11,8'h11,8'h11,8'h0F,8'h00},
      '{8'h1F,8'h01,8'h01,8'h0F,8'h01,8'h01,8'h1F,8'h00},
      '{8'h1F,8'h01,8'h01,8'h0F,8'h01,8'h01,8'h01,8'h00},
      '{8'h0E,8'h11,8'h01,8'h1D,8'h11,8'h11,8'h0E,8'h00},
      '{8'h11,8'h11,8'h11,8'h1F,8'h11,8'h11,8'h11,8'h00},
      '{8'h0E,8'h04,8'h04,8'h04,8'h04,8'h04,8'h0E,8'h00},
      '{8'h1C,8'h08,8'h08,8'h08,8'h09,8'h09,8'h06,8'h00},
      '{8'h11,8'h09,8'h05,8'h03,8'h05,8'h09,8'h11,8'h00},
      '{8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h1F,8'h00},
      '{8'h11,8'h1B,8'h15,8'h15,8'h11,8'h11,8'h11,8'h00},
      '{8'h11,8'h11,8'h13,8'h15,8'h19,8'h11,8'h11,8'h00},
      '{8'h0E,8'h11,8'h11,8'h11,8'h11,8'h11,8'h0E,8'h00},
      '{8'h0F,8'h11,8'h11,8'h0F,8'h01,8'h01,8'h01,8'h00},
      '{8'h0E,8'h11,8'h11,8'h11,8'h15,8'h09,8'h16,8'h00},
      '{8'h0F,8'h11,8'h11,8'h0F,8'h05,8'h09,8'h11,8'h00},
      '{8'h1E,8'h01,8'h01,8'h0E,8'h10,8'h10,8'h0F,8'h00},
      '{8'h1F,8'h04,8'h04,8'h04,8'h04,8'h04,8'h04,8'h00},
      '{8'h11,8'h11,8'h11,8'h11,8'h11,8'h11,8'h0E,8'h00},
      '{8'h11,8'h11,8'h11,8'h11,8'h11,8'h0A,8'h04,8'h00},
      '{8'h11,8'h11,8'h11,8'h15,8'h15,8'h1B,8'h11,8'h00},
      '{8'h11,8'h11,8'h0A,8'h04,8'h0A,8'h11,8'h11,8'h00},
      '{8'h11,8'h11,8'h0A,8'h04,8'h04,8'h04,8'h04,8'h00},
      '{8'h1F,8'h10,8'h08,8'h04,8'h02,8'h01,8'h1F,8'h00}
   };

   localparam int NUM_PUNCT = 23;

   localparam logic [7:0] PUNCT_CODES [NUM_PUNCT] = '{
      8'd32, 8'd46, 8'd44, 8'd58, 8'd59, 8'd33, 8'd63, 8'd45, 8'd95, 8'd43, 8'd61, 8'd42,
      8'd47, 8'd92, 8'd40, 8'd41, 8'd91, 8'd93, 8'd60, 8'd62, 8'd35, 8'd39, 8'd34
   };

   localparam glyph_type FONT_PUNCT [NUM_PUNCT] = '{
      '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
      '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h06,8'h06,8'h00},
      '{8'h00,8'h00,8'h00,8'h00,8'h06,8'h06,8'h02,8'h00},
      '{8'h00,8'h06,8'h06,8'h00,8'h06,8'h06,8'h00,8'h00},
      '{8'h00,8'h06,8'h06,8'h00,8'h06,8'h06,8'h02,8'h00},
      '{8'h04,8'h04,8'h04,8'h04,8'h04,8'h00,8'h04,8'h00},
      '{8'h0E,8'h11,8'h08,8'h04,8'h04,8'h00,8'h04,8'h00},
      '{8'h00,8'h00,8'h00,8'h1F,8'h00,8'h00,8'h00,8'h00},
      '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h1F,8'h00},
      '{8'h00,8'h04,8'h04,8'h1F,8'h04,8'h04,8'h00,8'h00},
      '{8'h00,8'h00,8'h1F,8'h00,8'h1F,8'h00,8'h00,8'h00},
      '{8'h00,8'h0A,8'h04,8'h1F,8'h04,8'h0A,8'h00,8'h00},
      '{8'h10,8'h08,8'h08,8'h04,8'h02,8'h02,8'h01,8'h00},
      '{8'h01,8'h02,8'h02,8'h04,8'h08,8'h08,8'h10,8'h00},
      '{8'h04,8'h02,8'h01,8'h01,8'h01,8'h02,8'h04,8'h00},
      '{8'h04,8'h08,8'h10,8'h10,8'h10,8'h08,8'h04,8'h00},
      '{8'h0E,8'h02,8'h02,8'h02,8'h02,8'h02,8'h0E,8'h00},
      '{8'h0E,8'h08,8'h08,8'h08,8'h08,8'h08,8'h0E,8'h00},
      '{8'h10,8'h08,8'h04,8'h02,8'h04,8'h08,8'h10,8'h00},
      '{8'h01,8'h02,8'h04,8'h08,8'h04,8'h02,8'h01,8'h00},
      '{8'h0A,8'h0A,8'h1F,8'h0A,8'h1F,8'h0A,8'h0A,8'h00},
      '{8'h04,8'h04,8'h04,8'h00,8'h00,8'h00,8'h00,8'h00},
      '{8'h0A,8'h0A,8'h0A,8'h00,8'h00,8'h00,8'h00,8'h00}
   };

   // drawn for every code without a glyph of its own
   localparam glyph_type FONT_BOX = '{8'h1F,8'h11,8'h11,8'h11,8'h11,8'h11,8'h1F,8'h00};

   // font lookup with lowercase folded onto uppercase
   function automatic glyph_type glyph_lookup(input logic [7:0] code);
      logic [7:0] c;
      logic [7:0] off;
      logic       hit;
      glyph_type  g;
      c   = code;
      off = '0;
      hit = 1'b0;
      g   = FONT_BOX;
      if (c >= 8'd97 && c <= 8'd122) begin
         c = c - 8'd32;
      end
      if (c >= 8'd48 && c <= 8'd57) begin
         off = c - 8'd48;
         g   = FONT_DIGITS[off[3:0]];
      end else if (c >= 8'd65 && c <= 8'd90) begin
         off = c - 8'd65;
         g   = FONT_LETTERS[off[4:0]];
      end else begin
         for (int i = 0; i < NUM_PUNCT; i++) begin
            if (!hit && c == PUNCT_CODES[i]) begin
               g   = FONT_PUNCT[i];
               hit = 1'b1;
            end
         end
      end
      return g;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/bitmap_text_rasterizer_top.sv */
// top level of the bitmap text rasterizer: register bank, config limits and glyph engine
//
// Usage: software writes origin, scale, surface size and colour over the APB-style
// port while the block is idle, then sends one character code per transfer on the
// req channel (valid/ready). Each drawn character returns 8*scale row spans on the
// rsp channel, one per cycle while rsp_ready is high, each with a row, a start
// column, a clipped 64-bit pixel mask and the colour; the final span of the
// character carries last_row. Newline and code zero return nothing.
// After the input transfer the engine decodes the glyph, then registers the first
// span. Busy: a drawn character holds the engine through accept, glyph decode, one
// span per cycle through the shared row adder while rsp_ready is high, and cursor
// advance; newline and code zero pass accept and decode only. req_ready is high
// only while idle. Stall: a span waits in the output register while rsp_ready is
// low and the row sequencer holds; nothing is dropped.
// Reset (synchronous): registers return to origin 0,0, scale 1, 640x480, white,
// the cursor to 0,0 and both channels empty. No clearing pass is needed.
`default_nettype none

module bitmap_text_rasterizer_top
   import txr_pkg::*;
#(
   parameter int MAX_SCALE = MAX_SCALE_DEFAULT,
   parameter int MAX_DIM   = MAX_DIM_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [ADDR_BITS-1:0] paddr,
   input  wire logic [31:0]          pwdata,
   output logic      [31:0]          prdata,
   output logic                      pready,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp_data
);

   cfg_type cfg_raw;
   cfg_type cfg_eff;

   txr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg_raw)
   );

   // limit scale to 1..MAX_SCALE and surface size to MAX_DIM
   always_comb begin
      cfg_eff = cfg_raw;
      if (cfg_raw.glyph_scale == 4'd0) begin
         cfg_eff.glyph_scale = 4'd1;
      end else if (cfg_raw.glyph_scale > 4'(MAX_SCALE)) begin
         cfg_eff.glyph_scale = 4'(MAX_SCALE);
      end
      if (16'(cfg_raw.surface_width) > 16'(MAX_DIM)) begin
         cfg_eff.surface_width = 13'(MAX_DIM);
      end
      if (16'(cfg_raw.surface_height) > 16'(MAX_DIM)) begin
         cfg_eff.surface_height = 13'(MAX_DIM);
      end
   end

   txr_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_eff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* rtl/core/txr_csr.sv */
// register bank of the text rasterizer behind an APB-style port
`default_nettype none

module txr_csr
   import txr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [ADDR_BITS-1:0] paddr,
   input  wire logic [31:0]          pwdata,
   output logic      [31:0]          prdata,
   output logic                      pready,
   output cfg_type                   cfg
);

   logic signed [15:0] origin_x_ff, origin_x_in;
   logic signed [15:0] origin_y_ff, origin_y_in;
   logic [3:0]         glyph_scale_ff, glyph_scale_in;
   logic [12:0]        surface_width_ff, surface_width_in;
   logic [12:0]        surface_height_ff, surface_height_in;
   logic [31:0]        draw_color_ff, draw_color_in;
   logic               wr_en;
   logic [2:0]         reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[ADDR_BITS-1:2];

   // write decode
   always_comb begin
      origin_x_in       = origin_x_ff;
      origin_y_in       = origin_y_ff;
      glyph_scale_in    = glyph_scale_ff;
      surface_width_in  = surface_width_ff;
      surface_height_in = surface_height_ff;
      draw_color_in     = draw_color_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_ORIGIN_X:       origin_x_in       = pwdata[15:0];
            REG_ORIGIN_Y:       origin_y_in       = pwdata[15:0];
            REG_GLYPH_SCALE:    glyph_scale_in    = pwdata[3:0];
            REG_SURFACE_WIDTH:  surface_width_in  = pwdata[12:0];
            REG_SURFACE_HEIGHT: surface_height_in = pwdata[12:0];
            REG_DRAW_COLOR:     draw_color_in     = pwdata;
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (reg_sel)
         REG_ORIGIN_X:       prdata = {16'd0, origin_x_ff};
         REG_ORIGIN_Y:       prdata = {16'd0, origin_y_ff};
         REG_GLYPH_SCALE:    prdata = {28'd0, glyph_scale_ff};
         REG_SURFACE_WIDTH:  prdata = {19'd0, surface_width_ff};
         REG_SURFACE_HEIGHT: prdata = {19'd0, surface_height_ff};
         REG_DRAW_COLOR:     prdata = draw_color_ff;
         default:            prdata = '0;
      endcase
   end

   // register storage
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff       <= ORIGIN_X_RESET;
         origin_y_ff       <= ORIGIN_Y_RESET;
         glyph_scale_ff    <= GLYPH_SCALE_RESET;
         surface_width_ff  <= SURFACE_WIDTH_RESET;
         surface_height_ff <= SURFACE_HEIGHT_RESET;
         draw_color_ff     <= DRAW_COLOR_RESET;
      end else begin
         origin_x_ff       <= origin_x_in;
         origin_y_ff       <= origin_y_in;
         glyph_scale_ff    <= glyph_scale_in;
         surface_width_ff  <= surface_width_in;
         surface_height_ff <= surface_height_in;
         draw_color_ff     <= draw_color_in;
      end
   end

   assign cfg.origin_x       = origin_x_ff;
   assign cfg.origin_y       = origin_y_ff;
   assign cfg.glyph_scale    = glyph_scale_ff;
   assign cfg.surface_width  = surface_width_ff;
   assign cfg.surface_height = surface_height_ff;
   assign cfg.draw_color     = draw_color_ff;

endmodule

`default_nettype wire

/* rtl/core/txr_engine.sv */
// cursor, glyph sequencer and shared row adder of the text rasterizer
`default_nettype none

module txr_engine
   import txr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ROWS,
      ST_FINISH
   } state_type;

   state_type              state_ff, state_in;
   logic [7:0]             code_ff, code_in;
   logic signed [15:0]     cx_ff, cx_in;
   logic signed [15:0]     cy_ff, cy_in;
   glyph_type              glyph_ff, glyph_in;
   logic [MASK_BITS-1:0]   clip_ff, clip_in;
   logic [5:0]             r_ff, r_in;
   logic [2:0]             sub_ff, sub_in;
   logic [2:0]             grow_ff, grow_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic [6:0]             cell_w;
   logic [5:0]             cell_m1;
   logic signed [17:0]     add_a, add_b, add_sum;
   logic                   add_sub;
   logic                   row_ok;
   logic                   row_last;
   logic                   row_load;
   logic [7:0]             row_bits;
   logic [MASK_BITS-1:0]   row_scaled;
   logic [6:0]             clip_lo, clip_hi;
   logic [MASK_BITS-1:0]   clip_calc;

   // clamp an intermediate sum to the cursor range
   function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
      logic signed [15:0] s;
      if (v > 18'sd32767) begin
         s = 16'sh7FFF;
      end else if (v < -18'sd32768) begin
         s = 16'sh8000;
      end else begin
         s = v[15:0];
      end
      return s;
   endfunction

   // magnify one font row: font column j fills scale adjacent mask bits
   function automatic logic [MASK_BITS-1:0] scale_row(input logic [7:0] bits,
                                                      input logic [3:0] sc);
      logic [MASK_BITS-1:0] m;
      m = '0;
      for (int s = 1; s <= 8; s++) begin
         if (sc == 4'(s)) begin
            for (int j = 0; j < 8; j++) begin
               for (int t = 0; t < s; t++) begin
                  m[j * s + t] = bits[j];
               end
            end
         end
      end
      return m;
   endfunction

   assign cell_w    = {cfg.glyph_scale[3:0], 3'b000};
   assign cell_m1   = 6'(cell_w - 7'd1);
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // shared adder: clip edge, newline step, row number and cursor advance
   always_comb begin
      add_a   = 18'(cx_ff);
      add_b   = {11'd0, cell_w};
      add_sub = 1'b0;
      case (state_ff)
         ST_DECODE: begin
            if (code_ff == CODE_NEWLINE) begin
               add_a = 18'(cy_ff);
               add_b = {11'd0, cell_w};
            end else begin
               add_a   = {5'd0, cfg.surface_width};
               add_b   = 18'(cx_ff);
               add_sub = 1'b1;
            end
         end
         ST_ROWS: begin
            add_a = 18'(cy_ff);
            add_b = {12'd0, r_ff};
         end
         default: ;
      endcase
      add_sum = add_a + (add_sub ? ~add_b : add_b) + {17'd0, add_sub};
   end

   // column window of the character, from the left surface edge and width - x
   always_comb begin
      if (add_sum[17] || add_sum == '0) begin
         clip_hi = 7'd0;
      end else if (add_sum > 18'sd64) begin
         clip_hi = 7'd64;
      end else begin
         clip_hi = add_sum[6:0];
      end
      if (!cx_ff[15]) begin
         clip_lo = 7'd0;
      end else if (cx_ff < -16'sd64) begin
         clip_lo = 7'd64;
      end else begin
         clip_lo = ~cx_ff[6:0] + 7'd1;
      end
      for (int k = 0; k < MASK_BITS; k++) begin
         clip_calc[k] = (7'(k) >= clip_lo) && (7'(k) < clip_hi);
      end
   end

   // current row of the glyph
   assign row_bits   = glyph_ff[grow_ff];
   assign row_scaled = scale_row(row_bits, cfg.glyph_scale);
   assign row_ok     = !add_sum[17] && (add_sum < $signed({5'd0, cfg.surface_height}));
   assign row_last   = (r_ff == cell_m1);
   assign row_load   = (state_ff == ST_ROWS) && (!rsp_valid_ff || rsp_ready);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      glyph_in     = glyph_ff;
      clip_in      = clip_ff;
      r_in         = r_ff;
      sub_in       = sub_ff;
      grow_in      = grow_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               code_in = req_data.char_code;
               if (req_data.first_of_text) begin
                  cx_in = cfg.origin_x;
                  cy_in = cfg.origin_y;
               end
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (code_ff == CODE_NUL) begin
               state_in = ST_IDLE;
            end else if (code_ff == CODE_NEWLINE) begin
               cx_in    = cfg.origin_x;
               cy_in    = sat16(add_sum);
               state_in = ST_IDLE;
            end else begin
               glyph_in = glyph_lookup(code_ff);
               clip_in  = clip_calc;
               r_in     = '0;
               sub_in   = '0;
               grow_in  = '0;
               state_in = ST_ROWS;
            end
         end
         ST_ROWS: begin
            if (row_load) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.row_y        = add_sum[15:0];
               rsp_data_in.span_x       = cx_ff;
               rsp_data_in.pixel_mask   = row_scaled & clip_ff & {MASK_BITS{row_ok}};
               rsp_data_in.pixel_color  = cfg.draw_color;
               rsp_data_in.last_row     = row_last;
               if (row_last) begin
                  state_in = ST_FINISH;
               end else begin
                  r_in = r_ff + 6'd1;
                  if ({1'b0, sub_ff} == cfg.glyph_scale - 4'd1) begin
                     sub_in  = '0;
                     grow_in = grow_ff + 3'd1;
                  end else begin
                     sub_in = sub_ff + 3'd1;
                  end
               end
            end
         end
         ST_FINISH: begin
            cx_in    = sat16(add_sum);
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cx_ff        <= '0;
         cy_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cx_ff        <= cx_in;
         cy_ff        <= cy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      code_ff     <= code_in;
      glyph_ff    <= glyph_in;
      clip_ff     <= clip_in;
      r_ff        <= r_in;
      sub_ff      <= sub_in;
      grow_ff     <= grow_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTH
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("engine took a second character while busy");

   a_row_in_cell: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROWS |-> r_ff <= cell_m1)
      else $error("row counter ran past the character cell");

   a_sub_in_scale: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROWS |-> {1'b0, sub_ff} < cfg.glyph_scale)
      else $error("sub-row counter reached the scale");

   a_last_then_finish: assert property (@(posedge clock) disable iff (reset)
      row_load && row_last |=> state_ff == ST_FINISH && rsp_valid_ff && rsp_data_ff.last_row)
      else $error("last row did not close the character");
`endif

endmodule

`default_nettype wire
